@@ hdl/sbb_pkg.sv @@
// Shared types, constants and arithmetic helpers of the spectrum band ballistics block.
`default_nettype none

package sbb_pkg;

    localparam int NUM_BANDS_DEF = 64;
    localparam int QUEUE_DEPTH   = 2;
    localparam int LEVEL_W       = 16;
    localparam int INDEX_W       = 6;
    localparam int BLUR_W        = 9;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int WIDE_W        = 19;

    localparam logic        [15:0] ALPHA_ATTACK_RESET  = 16'd32768;
    localparam logic        [15:0] ALPHA_RELEASE_RESET = 16'd8192;
    localparam logic signed [15:0] FLOOR_RESET         = -16'sd30720;
    localparam logic signed [15:0] CEILING_RESET       = 16'sd0;
    localparam logic        [8:0]  BLUR_RESET          = 9'd0;
    localparam logic        [15:0] HOLD_RESET          = 16'd15;
    localparam logic signed [15:0] DECAY_RESET         = 16'sd256;
    localparam logic signed [15:0] ACCEL_RESET         = 16'sd0;

    // Headroom above the ceiling for the smoothed level: 12 dB in Q8.8.
    localparam logic signed [16:0] HEADROOM  = 17'sd3072;
    localparam logic signed [16:0] LEVEL_MAX = 17'sd32767;
    localparam logic        [8:0]  BLUR_FULL = 9'd256;
    localparam logic        [15:0] HOLD_MAX  = 16'hFFFF;

    typedef enum logic [2:0] {
        CFG_ALPHA_ATTACK  = 3'd0,
        CFG_ALPHA_RELEASE = 3'd1,
        CFG_FLOOR_DB      = 3'd2,
        CFG_CEILING_DB    = 3'd3,
        CFG_BLUR_STRENGTH = 3'd4,
        CFG_HOLD_FRAMES   = 3'd5,
        CFG_DECAY_STEP    = 3'd6,
        CFG_ACCEL_STEP    = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic        [15:0] alpha_attack;
        logic        [15:0] alpha_release;
        logic signed [15:0] floor_db;
        logic signed [15:0] ceiling_db;
        logic        [8:0]  blur_strength;
        logic        [15:0] hold_frames;
        logic signed [15:0] decay_step;
        logic signed [15:0] accel_step;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] level;
        logic               last;
        logic               frz;
    } item_t;

    typedef struct packed {
        logic signed [15:0] peak;
        logic        [15:0] hold;
        logic signed [15:0] fall;
    } peak_state_t;

    localparam peak_state_t PEAK_RESET = '{peak: FLOOR_RESET, hold: 16'd0, fall: 16'sd0};

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_SMOOTH,
        ST_BLUR,
        ST_EMIT1,
        ST_EMIT2
    } back_state_t;

    function automatic logic signed [WIDE_W-1:0] sx19(input logic signed [15:0] a);
        sx19 = $signed({{(WIDE_W-16){a[15]}}, a});
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [WIDE_W-1:0] v);
        if (v > $signed(19'sd32767)) begin
            sat16 = 16'sh7FFF;
        end else if (v < -$signed(19'sd32768)) begin
            sat16 = 16'sh8000;
        end else begin
            sat16 = $signed(v[15:0]);
        end
    endfunction

    // One frame of peak ballistics for a band that shows value v.
    function automatic peak_state_t peak_update(input peak_state_t cur,
                                                input logic signed [15:0] v,
                                                input logic frz,
                                                input cfg_t cfg);
        peak_state_t        nxt;
        logic signed [15:0] pk;
        logic        [15:0] hold_new;
        logic signed [15:0] fall_new;
        nxt      = cur;
        pk       = cur.peak;
        hold_new = cur.hold;
        fall_new = cur.fall;
        if (v > cur.peak) begin
            pk       = v;
            nxt.hold = 16'd0;
            nxt.fall = cfg.decay_step;
        end else if (!frz) begin
            if (cur.hold != HOLD_MAX) begin
                hold_new = cur.hold + 16'd1;
            end
            nxt.hold = hold_new;
            if (hold_new > cfg.hold_frames) begin
                fall_new = sat16(sx19(cur.fall) + sx19(cfg.accel_step));
                nxt.fall = fall_new;
                pk       = sat16(sx19(cur.peak) - sx19(fall_new));
            end
        end
        if (pk < cfg.floor_db) begin
            pk = cfg.floor_db;
        end
        nxt.peak    = pk;
        peak_update = nxt;
    endfunction

endpackage

`default_nettype wire

@@ hdl/spectrum_band_ballistics_core.sv @@
// Top level of the spectrum band ballistics block: configuration, front, queue and back.
//
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_ready    band_level, last_band, freeze_peaks
// output    out        out_valid / out_ready  band_index, smoothed_db, peak_db, frame_end
// config    in         cfg_we (no wait)       cfg_index, cfg_data
//
// The back sequencer takes the first band of a frame through the memory read,
// the multiply stage and the smooth stage; each later band adds the blur stage
// and an emit state, and the band that closes the frame adds a second emit state.
// After reset the back sweeps both band state memories once, and in_ready stays
// low for that time; configuration writes are taken as ever.
// A two-entry queue lets the front take new transfers while the back is busy,
// and a stalled output transfer holds the back in its emit state.
`default_nettype none

module spectrum_band_ballistics_core #(
    parameter int NUM_BANDS = sbb_pkg::NUM_BANDS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_ready,
    input  wire logic signed [15:0] band_level,
    input  wire logic               last_band,
    input  wire logic               freeze_peaks,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      logic [5:0]         band_index,
    output      logic signed [15:0] smoothed_db,
    output      logic signed [15:0] peak_db,
    output      logic               frame_end,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);

    localparam int POS_W  = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam int ITEM_W = $bits(sbb_pkg::item_t);
    localparam int QW     = POS_W + ITEM_W;

    sbb_pkg::cfg_t    cfg_reg;

    logic             clearing;
    logic             queue_full;
    logic             push;
    logic [POS_W-1:0] push_pos;
    sbb_pkg::item_t   push_item;
    logic             q_valid;
    logic             q_pop;
    logic [QW-1:0]    q_data;
    logic [POS_W-1:0] q_pos;
    sbb_pkg::item_t   q_item;

    // Configuration registers. The user must write them only while the block is
    // idle; the block itself does not enforce it. The datapath reads them directly.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.alpha_attack  <= sbb_pkg::ALPHA_ATTACK_RESET;
            cfg_reg.alpha_release <= sbb_pkg::ALPHA_RELEASE_RESET;
            cfg_reg.floor_db      <= sbb_pkg::FLOOR_RESET;
            cfg_reg.ceiling_db    <= sbb_pkg::CEILING_RESET;
            cfg_reg.blur_strength <= sbb_pkg::BLUR_RESET;
            cfg_reg.hold_frames   <= sbb_pkg::HOLD_RESET;
            cfg_reg.decay_step    <= sbb_pkg::DECAY_RESET;
            cfg_reg.accel_step    <= sbb_pkg::ACCEL_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                sbb_pkg::CFG_ALPHA_ATTACK:  cfg_reg.alpha_attack  <= cfg_data;
                sbb_pkg::CFG_ALPHA_RELEASE: cfg_reg.alpha_release <= cfg_data;
                sbb_pkg::CFG_FLOOR_DB:      cfg_reg.floor_db      <= $signed(cfg_data);
                sbb_pkg::CFG_CEILING_DB:    cfg_reg.ceiling_db    <= $signed(cfg_data);
                sbb_pkg::CFG_BLUR_STRENGTH:
                    cfg_reg.blur_strength <= cfg_data[sbb_pkg::BLUR_W-1:0];
                sbb_pkg::CFG_HOLD_FRAMES:   cfg_reg.hold_frames   <= cfg_data;
                sbb_pkg::CFG_DECAY_STEP:    cfg_reg.decay_step    <= $signed(cfg_data);
                sbb_pkg::CFG_ACCEL_STEP:    cfg_reg.accel_step    <= $signed(cfg_data);
                default:                    cfg_reg.accel_step    <= cfg_reg.accel_step;
            endcase
        end
    end

    // The front numbers each band and decides where the frame ends.
    sbb_front #(
        .NUM_BANDS (NUM_BANDS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .band_level   (band_level),
        .last_band    (last_band),
        .freeze_peaks (freeze_peaks),
        .clearing     (clearing),
        .queue_full   (queue_full),
        .push         (push),
        .push_pos     (push_pos),
        .push_item    (push_item)
    );

    sbb_queue #(
        .WIDTH (QW),
        .DEPTH (sbb_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  ({push_pos, push_item}),
        .full       (queue_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_data)
    );

    assign q_pos  = q_data[QW-1:ITEM_W];
    assign q_item = sbb_pkg::item_t'(q_data[ITEM_W-1:0]);

    // The back smooths, blurs and runs the peak hold. Each band's result goes
    // out when the next band arrives, because the blur needs its right
    // neighbor; the closing band also sends its own result right after.
    sbb_back #(
        .NUM_BANDS (NUM_BANDS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (q_valid),
        .q_pos       (q_pos),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .clearing    (clearing),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .band_index  (band_index),
        .smoothed_db (smoothed_db),
        .peak_db     (peak_db),
        .frame_end   (frame_end)
    );

`ifndef SYNTHESIS
    // No input transfer may slip in while the band memories are being swept.
    a_no_input_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        clearing |-> !in_ready
    ) else $error("input taken during memory sweep");

    // No result can exist before the sweep has finished.
    a_no_result_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        clearing |-> !out_valid
    ) else $error("result offered during memory sweep");

    // The queue head is only retired once a band has been worked on.
    a_pop_only_with_item: assert property (
        @(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid
    ) else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire

@@ hdl/sbb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sbb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [AW-1:0]         waddr,
    input  wire logic [WIDTH-1:0]      wdata,
    input  wire logic                  re,
    input  wire logic [AW-1:0]         raddr,
    output      logic [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hdl/sbb_queue.sv @@
// Short register queue between the front and the back of the block.
`default_nettype none

module sbb_queue #(
    parameter int WIDTH = 24,
    parameter int DEPTH = sbb_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output      logic             full,
    input  wire logic             pop,
    output      logic             head_valid,
    output      logic [WIDTH-1:0] head_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];

endmodule

`default_nettype wire

@@ hdl/sbb_front.sv @@
// Front end: accepts band items, tracks the band position and marks the frame end.
`default_nettype none

module sbb_front #(
    parameter int NUM_BANDS = sbb_pkg::NUM_BANDS_DEF,
    localparam int POS_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_ready,
    input  wire logic signed [15:0] band_level,
    input  wire logic               last_band,
    input  wire logic               freeze_peaks,
    input  wire logic               clearing,
    input  wire logic               queue_full,
    output      logic               push,
    output      logic [POS_W-1:0]   push_pos,
    output      sbb_pkg::item_t     push_item
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             is_last;

    // The band at the top position closes the frame even without the marker.
    assign is_last  = last_band || (pos_reg == POS_W'(NUM_BANDS - 1));
    assign in_ready = !queue_full && !clearing;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        pos_next = pos_reg;
        if (push) begin
            pos_next = is_last ? '0 : pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    assign push_pos        = pos_reg;
    assign push_item.level = band_level;
    assign push_item.last  = is_last;
    assign push_item.frz   = freeze_peaks;

endmodule

`default_nettype wire

@@ hdl/sbb_back.sv @@
// Back end: smoothing, blur and peak ballistics sequencer with the band state memories.
`default_nettype none

module sbb_back #(
    parameter int NUM_BANDS = sbb_pkg::NUM_BANDS_DEF,
    localparam int POS_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sbb_pkg::cfg_t      cfg,
    input  wire logic               q_valid,
    input  wire logic [POS_W-1:0]   q_pos,
    input  wire sbb_pkg::item_t     q_item,
    output      logic               q_pop,
    output      logic               clearing,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      logic [5:0]         band_index,
    output      logic signed [15:0] smoothed_db,
    output      logic signed [15:0] peak_db,
    output      logic               frame_end
);

    localparam int EXT_W = POS_W + sbb_pkg::INDEX_W;
    localparam int PK_W  = $bits(sbb_pkg::peak_state_t);

    sbb_pkg::back_state_t state_reg, state_next;
    logic [POS_W-1:0]     clr_addr_reg, clr_addr_next;

    logic signed [33:0]   prod_reg;
    logic signed [15:0]   prev_reg;
    logic signed [15:0]   sm_reg;
    logic signed [15:0]   v_reg;
    logic signed [15:0]   prior0_reg, prior1_reg;

    logic                 out_valid_reg;
    logic [5:0]           out_index_reg;
    logic signed [15:0]   out_smooth_reg;
    logic signed [15:0]   out_peak_reg;
    logic                 out_end_reg;

    // Memory ports.
    logic                 sm_we, sm_re, pk_we, pk_re;
    logic [POS_W-1:0]     sm_waddr, sm_raddr, pk_waddr, pk_raddr;
    logic [15:0]          sm_wdata, sm_rdata;
    logic [PK_W-1:0]      pk_wdata, pk_rdata;

    logic                 slot_free;
    logic                 load_out;
    logic                 shift_prior;
    logic [POS_W-1:0]     j_pos;
    logic [POS_W-1:0]     emit_addr;
    logic [EXT_W-1:0]     emit_ext;
    logic signed [15:0]   emit_value;
    sbb_pkg::peak_state_t peak_cur, peak_new;

    // Datapath.
    logic signed [15:0]   prev;
    logic signed [16:0]   diff;
    logic        [15:0]   alpha;
    logic signed [33:0]   prod_full;
    logic signed [33:0]   prod_rnd;
    logic signed [18:0]   smooth_sum;
    logic signed [16:0]   ceil_wide;
    logic signed [15:0]   hi_bound;
    logic signed [15:0]   sm_next;
    logic        [8:0]    blur_k;
    logic signed [18:0]   blur_d;
    logic signed [28:0]   blur_x;
    logic signed [28:0]   blur_rnd;
    logic signed [15:0]   v_next;

    sbb_ram #(
        .WIDTH (16),
        .DEPTH (NUM_BANDS)
    ) u_smooth_ram (
        .clk   (clk),
        .we    (sm_we),
        .waddr (sm_waddr),
        .wdata (sm_wdata),
        .re    (sm_re),
        .raddr (sm_raddr),
        .rdata (sm_rdata)
    );

    sbb_ram #(
        .WIDTH (PK_W),
        .DEPTH (NUM_BANDS)
    ) u_peak_ram (
        .clk   (clk),
        .we    (pk_we),
        .waddr (pk_waddr),
        .wdata (pk_wdata),
        .re    (pk_re),
        .raddr (pk_raddr),
        .rdata (pk_rdata)
    );

    assign slot_free = !out_valid_reg || out_ready;
    assign clearing  = (state_reg == sbb_pkg::ST_CLEAR);
    assign j_pos     = q_pos - POS_W'(1);

    // Smoothing: multiply stage, then round, add and clamp.
    always_comb
    begin
        prev       = $signed(sm_rdata);
        diff       = $signed({q_item.level[15], q_item.level}) - $signed({prev[15], prev});
        alpha      = (q_item.level > prev) ? cfg.alpha_attack : cfg.alpha_release;
        prod_full  = $signed({18'd0, alpha}) * $signed({{17{diff[16]}}, diff});
        prod_rnd   = prod_reg + 34'sd32768;
        smooth_sum = sbb_pkg::sx19(prev_reg) + $signed({prod_rnd[33], prod_rnd[33:16]});
        ceil_wide  = $signed({cfg.ceiling_db[15], cfg.ceiling_db}) + sbb_pkg::HEADROOM;
        hi_bound   = (ceil_wide > sbb_pkg::LEVEL_MAX) ? 16'sh7FFF : $signed(ceil_wide[15:0]);
        if (smooth_sum < sbb_pkg::sx19(cfg.floor_db)) begin
            sm_next = cfg.floor_db;
        end else if (smooth_sum > sbb_pkg::sx19(hi_bound)) begin
            sm_next = hi_bound;
        end else begin
            sm_next = $signed(smooth_sum[15:0]);
        end
    end

    // Blur: M + k * (L - 2M + R) / 1024, rounded; the first band passes unchanged.
    always_comb
    begin
        blur_k   = cfg.blur_strength[8] ? sbb_pkg::BLUR_FULL : cfg.blur_strength;
        blur_d   = sbb_pkg::sx19(prior0_reg) - (sbb_pkg::sx19(prior1_reg) <<< 1)
                 + sbb_pkg::sx19(sm_reg);
        blur_x   = $signed({20'd0, blur_k}) * $signed({{10{blur_d[18]}}, blur_d});
        blur_rnd = blur_x + 29'sd512;
        if (q_pos == POS_W'(1)) begin
            v_next = prior1_reg;
        end else begin
            v_next = sbb_pkg::sat16(sbb_pkg::sx19(prior1_reg) + blur_rnd[28:10]);
        end
    end

    // Peak ballistics for the band being emitted.
    always_comb
    begin
        emit_addr  = (state_reg == sbb_pkg::ST_EMIT2) ? q_pos : j_pos;
        emit_value = (state_reg == sbb_pkg::ST_EMIT2) ? sm_reg : v_reg;
        emit_ext   = EXT_W'(emit_addr);
        peak_cur   = sbb_pkg::peak_state_t'(pk_rdata);
        peak_new   = sbb_pkg::peak_update(peak_cur, emit_value, q_item.frz, cfg);
    end

    // Next state.
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        case (state_reg)
            sbb_pkg::ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + POS_W'(1);
                if (clr_addr_reg == POS_W'(NUM_BANDS - 1)) begin
                    state_next = sbb_pkg::ST_IDLE;
                end
            end
            sbb_pkg::ST_IDLE:
            begin
                if (q_valid) begin
                    state_next = sbb_pkg::ST_MUL;
                end
            end
            sbb_pkg::ST_MUL:
            begin
                state_next = sbb_pkg::ST_SMOOTH;
            end
            sbb_pkg::ST_SMOOTH:
            begin
                if (q_pos != '0) begin
                    state_next = sbb_pkg::ST_BLUR;
                end else if (q_item.last) begin
                    state_next = sbb_pkg::ST_EMIT2;
                end else begin
                    state_next = sbb_pkg::ST_IDLE;
                end
            end
            sbb_pkg::ST_BLUR:
            begin
                state_next = sbb_pkg::ST_EMIT1;
            end
            sbb_pkg::ST_EMIT1:
            begin
                if (slot_free) begin
                    state_next = q_item.last ? sbb_pkg::ST_EMIT2 : sbb_pkg::ST_IDLE;
                end
            end
            sbb_pkg::ST_EMIT2:
            begin
                if (slot_free) begin
                    state_next = sbb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sbb_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs and memory accesses.
    always_comb
    begin
        sm_we       = 1'b0;
        sm_waddr    = emit_addr;
        sm_wdata    = emit_value;
        sm_re       = 1'b0;
        sm_raddr    = q_pos;
        pk_we       = 1'b0;
        pk_waddr    = emit_addr;
        pk_wdata    = peak_new;
        pk_re       = 1'b0;
        pk_raddr    = q_pos;
        q_pop       = 1'b0;
        shift_prior = 1'b0;
        load_out    = 1'b0;
        case (state_reg)
            sbb_pkg::ST_CLEAR:
            begin
                sm_we    = 1'b1;
                sm_waddr = clr_addr_reg;
                sm_wdata = sbb_pkg::FLOOR_RESET;
                pk_we    = 1'b1;
                pk_waddr = clr_addr_reg;
                pk_wdata = sbb_pkg::PEAK_RESET;
            end
            sbb_pkg::ST_IDLE:
            begin
                if (q_valid) begin
                    sm_re    = 1'b1;
                    pk_re    = 1'b1;
                    pk_raddr = (q_pos == '0) ? q_pos : j_pos;
                end
            end
            sbb_pkg::ST_SMOOTH:
            begin
                if ((q_pos == '0) && !q_item.last) begin
                    q_pop       = 1'b1;
                    shift_prior = 1'b1;
                end
            end
            sbb_pkg::ST_EMIT1:
            begin
                if (slot_free) begin
                    sm_we    = 1'b1;
                    pk_we    = 1'b1;
                    load_out = 1'b1;
                    if (q_item.last) begin
                        pk_re = 1'b1;
                    end else begin
                        q_pop       = 1'b1;
                        shift_prior = 1'b1;
                    end
                end
            end
            sbb_pkg::ST_EMIT2:
            begin
                if (slot_free) begin
                    sm_we    = 1'b1;
                    pk_we    = 1'b1;
                    load_out = 1'b1;
                    q_pop    = 1'b1;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= sbb_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            prior0_reg    <= '0;
            prior1_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            // A frame's first band shifts in while its smoothed level is still
            // being registered, so it takes the value straight from the clamp.
            if (shift_prior) begin
                prior0_reg <= prior1_reg;
                prior1_reg <= (state_reg == sbb_pkg::ST_SMOOTH) ? sm_next : sm_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == sbb_pkg::ST_MUL) begin
            prod_reg <= prod_full;
            prev_reg <= prev;
        end
        if (state_reg == sbb_pkg::ST_SMOOTH) begin
            sm_reg <= sm_next;
        end
        if (state_reg == sbb_pkg::ST_BLUR) begin
            v_reg <= v_next;
        end
        if (load_out) begin
            out_index_reg  <= emit_ext[sbb_pkg::INDEX_W-1:0];
            out_smooth_reg <= emit_value;
            out_peak_reg   <= peak_new.peak;
            out_end_reg    <= (state_reg == sbb_pkg::ST_EMIT2);
        end
    end

    assign out_valid   = out_valid_reg;
    assign band_index  = out_index_reg;
    assign smoothed_db = out_smooth_reg;
    assign peak_db     = out_peak_reg;
    assign frame_end   = out_end_reg;

endmodule

`default_nettype wire

@@ dv/spectrum_band_ballistics_core_test.sv @@
// Self-checking testbench of the spectrum band ballistics core with a built-in band predictor.
module spectrum_band_ballistics_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    // The block keeps state for this many bands; longer frames close at the last slot.
    localparam int BANDS = sbb_pkg::NUM_BANDS_DEF;
    // Idle and stall rate of both channels, in percent.
    localparam int IDLE_PCT = 15;
    // Cycles allowed after the last result for the back end to finish any band
    // that produces nothing yet, such as the first band of a frame.
    localparam int SETTLE_CYCLES = 32;
    // Roughly 720 transfers in the worst case, plus the clearing sweep after reset
    // and the drains between configuration phases.
    localparam int CYCLE_LIMIT = 200000;

    // One band result as the block should present it on the output channel.
    typedef struct {
        logic [5:0]         idx;
        logic signed [15:0] level;
        logic signed [15:0] peak;
        logic               fin;
    } band_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [15:0] band_level = '0;
    logic               last_band = 1'b0;
    logic               freeze_peaks = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [5:0]         band_index;
    logic signed [15:0] smoothed_db;
    logic signed [15:0] peak_db;
    logic               frame_end;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;

    // Shadow copy of the configuration registers, kept in step with every write.
    logic [15:0]        attack_coef;
    logic [15:0]        release_coef;
    logic signed [15:0] floor_lvl;
    logic signed [15:0] ceil_lvl;
    logic [8:0]         blur_mix;
    logic [15:0]        hold_limit;
    logic signed [15:0] decay_init;
    logic signed [15:0] accel_delta;

    // Per-band state of the predictor.
    logic signed [15:0] smooth_mem [BANDS];
    logic signed [15:0] peak_mem [BANDS];
    logic [15:0]        hold_mem [BANDS];
    logic signed [15:0] fall_mem [BANDS];
    // The two most recent unblurred smoothed levels still waiting for a neighbor.
    logic signed [15:0] raw_left;
    logic signed [15:0] raw_mid;
    int                 band_pos;

    sbb_pkg::item_t     band_queue [$];
    band_result_t       results_due [$];
    sbb_pkg::item_t     next_item;
    band_result_t       seen_due;
    int                 band_base [BANDS];
    int                 queued_total = 0;
    int                 accepted_total = 0;
    int                 fault_count = 0;
    int                 cycle_count = 0;
    bit                 no_idle = 1'b0;

    spectrum_band_ballistics_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .band_level   (band_level),
        .last_band    (last_band),
        .freeze_peaks (freeze_peaks),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .band_index   (band_index),
        .smoothed_db  (smoothed_db),
        .peak_db      (peak_db),
        .frame_end    (frame_end),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Band predictor
    // ------------------------------------------------------------------

    function automatic logic signed [15:0] clip16(input longint v);
        if (v > 32767) begin
            return 16'sh7FFF;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // Divide by 2^sh, rounding to nearest with ties going up. The arithmetic
    // shift of a signed value floors, so adding half first gives the rounding.
    function automatic longint round_shift(input longint x, input int sh);
        return (x + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    // Attack/release smoothing toward the new level, then the clamp to the
    // floor and to the ceiling plus 12 dB. The floor test comes first, so a
    // floor set above the ceiling still wins for low values.
    function automatic logic signed [15:0] smooth_band(input logic signed [15:0] prev,
                                                       input logic signed [15:0] lvl);
        longint diff;
        longint coef;
        longint s;
        longint hi;
        diff = longint'(lvl) - longint'(prev);
        coef = (lvl > prev) ? longint'(attack_coef) : longint'(release_coef);
        s    = longint'(prev) + round_shift(coef * diff, 16);
        hi   = longint'(ceil_lvl) + 3072;
        if (hi > 32767) begin
            hi = 32767;
        end
        if (s < longint'(floor_lvl)) begin
            s = longint'(floor_lvl);
        end else if (s > hi) begin
            s = hi;
        end
        return clip16(s);
    endfunction

    // [1,2,1]/4 blur blended with the unblurred level; strengths above full
    // blur behave as full blur.
    function automatic logic signed [15:0] blur_band(input logic signed [15:0] l,
                                                     input logic signed [15:0] m,
                                                     input logic signed [15:0] r);
        longint k;
        longint sum4;
        longint mix;
        k    = (blur_mix > 9'd256) ? 256 : longint'(blur_mix);
        sum4 = longint'(l) + 2 * longint'(m) + longint'(r);
        mix  = (256 - k) * 4 * longint'(m) + k * sum4;
        return clip16(round_shift(mix, 10));
    endfunction

    // A band's displayed level is final: store it for the next frame, run the
    // peak cap for one frame and queue the result the block must present.
    task automatic close_band(input int j, input logic signed [15:0] v, input bit frz,
                              input bit fin);
        logic signed [15:0] pk;
        band_result_t       res;
        pk = peak_mem[j];
        smooth_mem[j] = v;
        if (v > pk) begin
            pk          = v;
            hold_mem[j] = '0;
            fall_mem[j] = decay_init;
        end else if (!frz) begin
            if (hold_mem[j] != 16'hFFFF) begin
                hold_mem[j] = hold_mem[j] + 16'd1;
            end
            if (hold_mem[j] > hold_limit) begin
                // A negative fall raises the peak; both steps saturate.
                fall_mem[j] = clip16(longint'(fall_mem[j]) + longint'(accel_delta));
                pk          = clip16(longint'(pk) - longint'(fall_mem[j]));
            end
        end
        if (pk < floor_lvl) begin
            pk = floor_lvl;
        end
        peak_mem[j] = pk;
        res.idx   = j[5:0];
        res.level = v;
        res.peak  = pk;
        res.fin   = fin;
        results_due.push_back(res);
    endtask

    // One accepted band. Its result waits for the following band, because the
    // blur needs the right-hand neighbor; the band that ends a frame releases
    // the pending band and then itself. The freeze flag of the releasing
    // transfer applies to both.
    task automatic predict_band(input logic signed [15:0] lvl, input bit last_in,
                                input bit frz);
        int                 i;
        bit                 fin;
        logic signed [15:0] sm;
        logic signed [15:0] v;
        i   = band_pos;
        // The last band slot closes the frame even when last_band is low.
        fin = last_in || (i >= BANDS - 1);
        sm  = smooth_band(smooth_mem[i], lvl);
        if (i > 0) begin
            // The frame's first band has no left neighbor and passes unblurred.
            v = (i == 1) ? raw_mid : blur_band(raw_left, raw_mid, sm);
            close_band(i - 1, v, frz, 1'b0);
        end
        if (fin) begin
            // The closing band has no right neighbor and passes unblurred too.
            close_band(i, sm, frz, 1'b1);
            band_pos = 0;
        end else begin
            raw_left = raw_mid;
            raw_mid  = sm;
            band_pos = i + 1;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_band(input logic signed [15:0] lvl, input bit fin, input bit frz);
        sbb_pkg::item_t it;
        it.level = lvl;
        it.last  = fin;
        it.frz   = frz;
        band_queue.push_back(it);
        queued_total++;
    endtask

    // Register writes go out one per clock; the shadow is updated at once,
    // which is safe because writes only happen while nothing is in flight.
    task automatic write_reg(input sbb_pkg::cfg_index_t idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            sbb_pkg::CFG_ALPHA_ATTACK:  attack_coef  = val;
            sbb_pkg::CFG_ALPHA_RELEASE: release_coef = val;
            sbb_pkg::CFG_FLOOR_DB:      floor_lvl    = val;
            sbb_pkg::CFG_CEILING_DB:    ceil_lvl     = val;
            sbb_pkg::CFG_BLUR_STRENGTH: blur_mix     = val[8:0];
            sbb_pkg::CFG_HOLD_FRAMES:   hold_limit   = val;
            sbb_pkg::CFG_DECAY_STEP:    decay_init   = val;
            sbb_pkg::CFG_ACCEL_STEP:    accel_delta  = val;
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [15:0] aa, input logic [15:0] ar,
                                input logic [15:0] fl, input logic [15:0] ce,
                                input logic [15:0] bl, input logic [15:0] ho,
                                input logic [15:0] de, input logic [15:0] ac);
        write_reg(sbb_pkg::CFG_ALPHA_ATTACK, aa);
        write_reg(sbb_pkg::CFG_ALPHA_RELEASE, ar);
        write_reg(sbb_pkg::CFG_FLOOR_DB, fl);
        write_reg(sbb_pkg::CFG_CEILING_DB, ce);
        write_reg(sbb_pkg::CFG_BLUR_STRENGTH, bl);
        write_reg(sbb_pkg::CFG_HOLD_FRAMES, ho);
        write_reg(sbb_pkg::CFG_DECAY_STEP, de);
        write_reg(sbb_pkg::CFG_ACCEL_STEP, ac);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // A display-like setting: short holds so that peaks fall within a run,
    // blur anywhere including past full strength.
    task automatic program_typical();
        int fl;
        int ce;
        int de;
        int ac;
        fl = -int'($urandom_range(16000, 30000));
        ce = int'($urandom_range(0, 6000)) - 3000;
        de = int'($urandom_range(0, 1024));
        ac = int'($urandom_range(0, 320)) - 64;
        program_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     fl[15:0], ce[15:0], 16'($urandom_range(0, 511)),
                     16'($urandom_range(0, 6)), de[15:0], ac[15:0]);
    endtask

    // Mostly well-formed frames whose levels follow a per-band profile that
    // moves from frame to frame, so peaks are set, held and left to fall.
    // A few frames run past the band count, and some are noise with random
    // levels and stray last_band marks. Every call ends on a closed frame.
    task automatic queue_frames(input int count);
        int n;
        int len;
        int b;
        int mode;
        int lvl;
        int swing;
        bit frz;
        bit fin;
        for (b = 0; b < BANDS; b++) begin
            band_base[b] = int'($urandom_range(0, 20000)) - 16000;
        end
        n = 0;
        while (n < count) begin
            mode  = $urandom_range(0, 99);
            len   = (mode < 4) ? $urandom_range(BANDS, BANDS + 8) : $urandom_range(1, 12);
            frz   = ($urandom_range(0, 9) == 0);
            swing = int'($urandom_range(0, 6144)) - 3072;
            for (b = 0; b < len; b++) begin
                fin = (b == len - 1);
                if (mode >= 88) begin
                    lvl = int'($urandom_range(0, 65535)) - 32768;
                    queue_band(lvl[15:0], fin || ($urandom_range(0, 5) == 0),
                               1'($urandom_range(0, 1)));
                end else begin
                    lvl = band_base[b % BANDS] + swing + int'($urandom_range(0, 1024)) - 512;
                    if ($urandom_range(0, 49) == 0) begin
                        lvl = $urandom_range(0, 1) ? 32767 : -32768;
                    end
                    queue_band(clip16(lvl), fin, frz);
                end
            end
            n += len;
        end
    endtask

    // Hold the sender until every queued band has been transferred and every
    // expected result has come back, then give the back end time to finish a
    // band that produces no result of its own.
    task automatic drain_results();
        do begin
            @(posedge clk);
        end while (accepted_total != queued_total || results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Input driver: one transfer per handshake, valid held until taken.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                predict_band(band_level, last_band, freeze_peaks);
                accepted_total++;
            end
            if (!in_valid || in_ready) begin
                if (band_queue.size() != 0 &&
                    (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    next_item = band_queue.pop_front();
                    in_valid     <= 1'b1;
                    band_level   <= next_item.level;
                    last_band    <= next_item.last;
                    freeze_peaks <= next_item.frz;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: every result transfer is matched against the oldest
    // expectation, field by field, with random stalls on out_ready.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (results_due.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("unexpected result: band %0d smoothed %0d peak %0d end %0b",
                                 band_index, smoothed_db, peak_db, frame_end);
                    end
                end else begin
                    seen_due = results_due.pop_front();
                    if (band_index !== seen_due.idx || smoothed_db !== seen_due.level ||
                        peak_db !== seen_due.peak || frame_end !== seen_due.fin) begin
                        fault_count++;
                        if (fault_count <= 10) begin
                            $display(
                                "mismatch exp/act: band %0d/%0d sm %0d/%0d pk %0d/%0d end %0b/%0b",
                                seen_due.idx, band_index, seen_due.level, smoothed_db,
                                seen_due.peak, peak_db, seen_due.fin, frame_end);
                        end
                    end
                end
            end
            out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // A hung handshake ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int b;
        int fl;
        int ce;
        int de;
        int ac;

        attack_coef  = sbb_pkg::ALPHA_ATTACK_RESET;
        release_coef = sbb_pkg::ALPHA_RELEASE_RESET;
        floor_lvl    = sbb_pkg::FLOOR_RESET;
        ceil_lvl     = sbb_pkg::CEILING_RESET;
        blur_mix     = sbb_pkg::BLUR_RESET;
        hold_limit   = sbb_pkg::HOLD_RESET;
        decay_init   = sbb_pkg::DECAY_RESET;
        accel_delta  = sbb_pkg::ACCEL_RESET;
        for (b = 0; b < BANDS; b++) begin
            smooth_mem[b] = sbb_pkg::FLOOR_RESET;
            peak_mem[b]   = sbb_pkg::FLOOR_RESET;
            hold_mem[b]   = '0;
            fall_mem[b]   = '0;
        end
        raw_left = '0;
        raw_mid  = '0;
        band_pos = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed bands at the reset settings. The first frame carries the
        // level extremes; then single-band frames, where only the closing
        // result appears; a two-band frame whose closing transfer freezes
        // both bands; and a short frame repeated so that peaks are held.
        queue_band(16'sh7FFF, 1'b0, 1'b0);
        queue_band(16'sh8000, 1'b0, 1'b0);
        queue_band(16'sh0000, 1'b0, 1'b1);
        queue_band(-16'sd1, 1'b1, 1'b0);
        queue_band(16'sh7FFF, 1'b1, 1'b0);
        queue_band(16'sh8000, 1'b1, 1'b1);
        queue_band(16'sd100, 1'b0, 1'b0);
        queue_band(-16'sd100, 1'b1, 1'b1);
        for (b = 0; b < 4; b++) begin
            queue_band(16'sh0400 - 16'(b * 1024), 1'b0, 1'b0);
            queue_band(16'shF000, 1'b0, 1'b0);
            queue_band(16'sh0100, 1'b1, b[0]);
        end
        drain_results();

        // Extremes: instant attack, frozen release, lowest floor, highest
        // ceiling, full blur, no hold, steepest fall with the strongest
        // braking.
        program_regs(16'hFFFF, 16'h0000, 16'h8000, 16'd29695, 16'd256, 16'h0000,
                     16'h7FFF, 16'h8000);
        queue_frames(110);
        drain_results();

        // Floor above the ceiling, blur past full strength, the longest hold,
        // and the opposite step extremes.
        fl = 1000;
        ce = -2000;
        program_regs(16'h0000, 16'hFFFF, fl[15:0], ce[15:0], 16'h01FF, 16'hFFFF,
                     16'h8000, 16'h7FFF);
        queue_frames(110);
        drain_results();

        // Negative fall steps, so caps rise once released and saturate at the
        // top. The sender also stops partway into a frame until every result
        // so far has come back.
        fl = -int'($urandom_range(20000, 28000));
        ce = int'($urandom_range(0, 2000)) - 1000;
        de = -int'($urandom_range(50, 600));
        ac = -int'($urandom_range(0, 40));
        program_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     fl[15:0], ce[15:0], 16'($urandom_range(0, 256)),
                     16'($urandom_range(0, 2)), de[15:0], ac[15:0]);
        queue_band(-16'sd2000, 1'b0, 1'b0);
        queue_band(-16'sd1500, 1'b0, 1'b0);
        queue_band(-16'sd2500, 1'b0, 1'b0);
        drain_results();
        queue_frames(110);
        drain_results();

        program_typical();
        queue_frames(115);
        drain_results();

        // Raw register values across the whole width, including the unused
        // upper bits of the blur strength.
        ce = int'($urandom_range(0, 62463)) - 32768;
        program_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), ce[15:0],
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        queue_frames(115);
        drain_results();

        // A long stretch with both channels running flat out.
        program_typical();
        no_idle = 1'b1;
        queue_frames(115);
        drain_results();
        no_idle = 1'b0;

        fault_count += results_due.size();
        if (fault_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
